// File: rtl/mbfc_pkg.sv
// ----------------------------------------------------------------------------
// mbfc_pkg: Modbus RTU frame checker shared definitions
// Verdict codes, field widths and the byte-wide Modbus CRC16 update.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfc_pkg;

  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned VERDICT_W = 3;

  typedef logic [7:0]           byte_t;
  typedef logic [15:0]          crc_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [VERDICT_W-1:0] verdict_t;

  localparam crc_t   CRC_POLY       = 16'hA001;
  localparam crc_t   CRC_INIT       = 16'hFFFF;
  localparam count_t MIN_FRAME      = 9'd4;
  localparam count_t HEADER_CRC_LEN = 9'd3;
  localparam byte_t  BROADCAST_ADDR = 8'h00;

  localparam verdict_t V_ACCEPT    = 3'd0;
  localparam verdict_t V_SHORT     = 3'd1;
  localparam verdict_t V_CRC       = 3'd2;
  localparam verdict_t V_MISMATCH  = 3'd3;
  localparam verdict_t V_BROADCAST = 3'd4;
  localparam verdict_t V_OVERLONG  = 3'd5;

  localparam logic CFG_SLAVE_ADDRESS  = 1'b0;
  localparam logic CFG_RECEIVE_ENABLE = 1'b1;

  function automatic crc_t crc_byte(input crc_t crc, input byte_t b);
    crc_t c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mbfc_if.sv
// ----------------------------------------------------------------------------
// mbfc_if: channel interfaces of the Modbus RTU frame checker
// Received byte channel and frame report channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbfc_rx_if;
  logic                 valid;
  logic                 ready;
  mbfc_pkg::byte_t      rx_byte;
  logic                 frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mbfc_report_if;
  logic                 valid;
  logic                 ready;
  mbfc_pkg::verdict_t   verdict;
  mbfc_pkg::count_t     frame_bytes;
  mbfc_pkg::count_t     pdu_bytes;
  mbfc_pkg::byte_t      frame_address;
  mbfc_pkg::byte_t      function_code;

  modport source (output valid, output verdict, output frame_bytes, output pdu_bytes,
                  output frame_address, output function_code, input ready);
  modport sink   (input valid, input verdict, input frame_bytes, input pdu_bytes,
                  input frame_address, input function_code, output ready);
endinterface

`default_nettype wire

// File: rtl/modbus_rtu_frame_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker: Modbus RTU frame receiver with CRC16 check
// Tracks CRC, byte count, address and function code over received bytes and
// reports one verdict word per frame on the byte flagged as frame end.
// ----------------------------------------------------------------------------
//   channel  | dir | word contents                                    | handshake
//   ---------+-----+--------------------------------------------------+----------
//   rx       | in  | rx_byte, frame_end                               | valid/ready
//   report   | out | verdict, frame_bytes, pdu_bytes, frame_address,  | valid/ready
//            |     | function_code                                    |
//   cfg      | in  | cfg_we, cfg_index, cfg_data                      | write only
//
// One byte per cycle if rx.ready; a report appears the cycle after its end byte.
// The frame state registers and the report register are the only stages.
// rx.ready drops only while a report word is held and report.ready is low.
// Synchronous reset clears frame state and report valid, sets address 1, enable 0.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_frame_checker #(
  parameter int unsigned MAX_FRAME = 260
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [7:0]      cfg_data,
  mbfc_rx_if.sink              rx,
  mbfc_report_if.source        report
);

  localparam mbfc_pkg::count_t MAX_COUNT = mbfc_pkg::count_t'(MAX_FRAME);

  mbfc_pkg::byte_t  slave_address;
  logic             receive_enable;

  mbfc_pkg::crc_t   running_crc;
  mbfc_pkg::count_t byte_count;
  mbfc_pkg::byte_t  address_seen;
  mbfc_pkg::byte_t  code_seen;
  logic             overlong_flag;

  mbfc_pkg::crc_t   crc_next;
  mbfc_pkg::count_t count_next;
  mbfc_pkg::byte_t  address_next;
  mbfc_pkg::byte_t  code_next;
  logic             overlong_next;
  mbfc_pkg::verdict_t verdict_next;
  mbfc_pkg::count_t pdu_next;

  logic rx_take;
  logic step;
  logic report_load;

  assign rx.ready    = !report.valid || report.ready;
  assign rx_take     = rx.valid && rx.ready;
  assign step        = rx_take && receive_enable;
  assign report_load = step && rx.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= 8'd1;
      receive_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mbfc_pkg::CFG_SLAVE_ADDRESS:  slave_address  <= cfg_data;
        mbfc_pkg::CFG_RECEIVE_ENABLE: receive_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    crc_next      = mbfc_pkg::crc_byte(running_crc, rx.rx_byte);
    count_next    = byte_count;
    address_next  = address_seen;
    code_next     = code_seen;
    overlong_next = overlong_flag;
    if (byte_count >= MAX_COUNT) begin
      overlong_next = 1'b1;
      count_next    = MAX_COUNT;
    end else begin
      if (byte_count == '0) begin
        address_next = rx.rx_byte;
      end else if (byte_count == mbfc_pkg::count_t'(1)) begin
        code_next = rx.rx_byte;
      end
      count_next = byte_count + mbfc_pkg::count_t'(1);
    end

    if (overlong_next) begin
      verdict_next = mbfc_pkg::V_OVERLONG;
    end else if (count_next < mbfc_pkg::MIN_FRAME) begin
      verdict_next = mbfc_pkg::V_SHORT;
    end else if (crc_next != '0) begin
      verdict_next = mbfc_pkg::V_CRC;
    end else if (address_next == slave_address) begin
      verdict_next = mbfc_pkg::V_ACCEPT;
    end else if (address_next == mbfc_pkg::BROADCAST_ADDR) begin
      verdict_next = mbfc_pkg::V_BROADCAST;
    end else begin
      verdict_next = mbfc_pkg::V_MISMATCH;
    end

    pdu_next = (count_next >= mbfc_pkg::MIN_FRAME) ?
               count_next - mbfc_pkg::HEADER_CRC_LEN : '0;
  end

  // advance frame state; clear it after the end byte
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc   <= mbfc_pkg::CRC_INIT;
      byte_count    <= '0;
      address_seen  <= '0;
      code_seen     <= '0;
      overlong_flag <= 1'b0;
    end else if (step) begin
      if (rx.frame_end) begin
        running_crc   <= mbfc_pkg::CRC_INIT;
        byte_count    <= '0;
        address_seen  <= '0;
        code_seen     <= '0;
        overlong_flag <= 1'b0;
      end else begin
        running_crc   <= crc_next;
        byte_count    <= count_next;
        address_seen  <= address_next;
        code_seen     <= code_next;
        overlong_flag <= overlong_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (report_load) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_load) begin
      report.verdict       <= verdict_next;
      report.frame_bytes   <= count_next;
      report.pdu_bytes     <= pdu_next;
      report.frame_address <= address_next;
      report.function_code <= code_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mbfc_checker.sv
// ----------------------------------------------------------------------------
// mbfc_checker: port-level checks for the Modbus RTU frame checker
// Watches the rx and report channels and the report word contents.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                rx_valid,
  input wire logic                rx_ready,
  input wire logic                rx_frame_end,
  input wire logic                rep_valid,
  input wire logic                rep_ready,
  input wire mbfc_pkg::verdict_t  verdict,
  input wire mbfc_pkg::count_t    frame_bytes,
  input wire mbfc_pkg::count_t    pdu_bytes
);

  a_rep_hold: assert property (@(posedge clk) disable iff (rst)
    rep_valid && !rep_ready |=> rep_valid && $stable(verdict) && $stable(frame_bytes))
    else $error("report word dropped or changed while stalled");

  a_rep_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rep_valid) |-> $past(rx_valid && rx_ready && rx_frame_end))
    else $error("report word without an accepted end byte");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    rep_valid |-> verdict <= mbfc_pkg::V_OVERLONG)
    else $error("verdict code out of range");

  a_pdu_len: assert property (@(posedge clk) disable iff (rst)
    rep_valid && frame_bytes >= mbfc_pkg::MIN_FRAME |->
      pdu_bytes == frame_bytes - mbfc_pkg::HEADER_CRC_LEN)
    else $error("pdu length does not match frame length");

  a_short_len: assert property (@(posedge clk) disable iff (rst)
    rep_valid && frame_bytes < mbfc_pkg::MIN_FRAME |->
      pdu_bytes == '0 && (verdict == mbfc_pkg::V_SHORT || verdict == mbfc_pkg::V_OVERLONG))
    else $error("short frame reported with wrong verdict or length");

endmodule

bind modbus_rtu_frame_checker mbfc_checker u_mbfc_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_valid     (rx.valid),
  .rx_ready     (rx.ready),
  .rx_frame_end (rx.frame_end),
  .rep_valid    (report.valid),
  .rep_ready    (report.ready),
  .verdict      (report.verdict),
  .frame_bytes  (report.frame_bytes),
  .pdu_bytes    (report.pdu_bytes)
);

`default_nettype wire
